@@ design/per_source_connection_and_auth_limiter_defines.svh @@
// Assertion macros used by the limiter back end.
`ifndef PER_SOURCE_CONNECTION_AND_AUTH_LIMITER_DEFINES_SVH
`define PER_SOURCE_CONNECTION_AND_AUTH_LIMITER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define PSL_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define PSL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/psl_pkg.sv @@
`default_nettype none
package psl_pkg;
  typedef enum logic [2:0] {
    ACT_ACQUIRE = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_QUERY   = 3'd2,
    ACT_FAIL    = 3'd3,
    ACT_TICK    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    CFG_ENABLE    = 3'd0,
    CFG_MAX_CONN  = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_WINDOW    = 3'd3,
    CFG_COOLDOWN  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] source_addr;
  } in_word_t;

  typedef struct packed {
    logic granted;
    logic in_cooldown;
    logic cooldown_started;
    logic table_full;
  } out_word_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] max_conn;
    logic [7:0]  threshold;
    logic [15:0] window;
    logic [15:0] cooldown;
  } cfg_t;
endpackage
`default_nettype wire

@@ design/psl_front.sv @@
`default_nettype none
// Accepts input words and holds them in a two-entry queue for the back end.
module psl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire psl_pkg::in_word_t in_data,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output psl_pkg::in_word_t      q_data
);
  psl_pkg::in_word_t buf_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) buf_r[wp_r] <= in_data;
  end
endmodule
`default_nettype wire

@@ design/psl_back.sv @@
`default_nettype none
`include "per_source_connection_and_auth_limiter_defines.svh"
// Looks the key up in the ST_LOOK state, updates the entry in the ST_EXEC state
// that follows and leaves the result in an output register.
module psl_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire psl_pkg::cfg_t     cfg,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire psl_pkg::in_word_t q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output psl_pkg::out_word_t     out_data
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic {ST_LOOK, ST_EXEC} state_t;
  state_t state_r;

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0] key_r  [TABLE_ENTRIES];
  logic [15:0] act_r  [TABLE_ENTRIES];
  logic [7:0]  fcnt_r [TABLE_ENTRIES];
  logic        wopen_r[TABLE_ENTRIES];
  logic [31:0] wst_r  [TABLE_ENTRIES];
  logic [31:0] cend_r [TABLE_ENTRIES];
  logic [31:0] now_r;

  psl_pkg::in_word_t item_r;
  logic              hit_r, free_r;
  logic [IW-1:0]     hidx_r, fidx_r;
  psl_pkg::out_word_t res_r;
  logic              ovalid_r;

  // Lookup: match and lowest free entry, each a flat search over the table.
  logic          hit_c, free_c;
  logic [IW-1:0] hidx_c, fidx_c;
  always_comb begin
    hit_c = 1'b0; hidx_c = '0; free_c = 1'b0; fidx_c = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == q_data.source_addr) begin
        hit_c = 1'b1; hidx_c = IW'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1; fidx_c = IW'(i);
      end
    end
  end

  assign q_ready   = (state_r == ST_LOOK) && (!ovalid_r || out_ready);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  // Execution step on the registered lookup.
  logic          acq_off, q_off, f_off, need_alloc, use_ok;
  logic [IW-1:0] ix;
  logic [15:0]   a_cur;
  logic [7:0]    f_cur, f_new;
  logic          w_cur;
  logic [31:0]   ws_cur, ce_cur, age;
  logic [32:0]   cend_sum;
  logic          restart;
  always_comb begin
    acq_off = !cfg.enable || cfg.max_conn == 16'd0;
    q_off   = !cfg.enable || cfg.threshold == 8'd0 || cfg.cooldown == 16'd0;
    f_off   = !cfg.enable || cfg.threshold == 8'd0 || cfg.window == 16'd0;
    need_alloc = !hit_r;
    ix     = hit_r ? hidx_r : fidx_r;
    use_ok = hit_r || free_r;
    a_cur  = hit_r ? act_r[ix] : 16'd0;
    f_cur  = hit_r ? fcnt_r[ix] : 8'd0;
    w_cur  = hit_r ? wopen_r[ix] : 1'b0;
    ws_cur = hit_r ? wst_r[ix] : 32'd0;
    ce_cur = hit_r ? cend_r[ix] : 32'd0;
    age    = now_r - ws_cur;
    restart = !w_cur || age > {16'd0, cfg.window};
    f_new  = restart ? 8'd1 : (f_cur != 8'hFF ? f_cur + 8'd1 : f_cur);
    cend_sum = {1'b0, now_r} + {17'd0, cfg.cooldown};
  end

  // Result word of the item being executed.
  psl_pkg::out_word_t res_c;
  always_comb begin
    res_c = '0;
    case (item_r.action)
      psl_pkg::ACT_ACQUIRE: begin
        if (acq_off) res_c.granted = 1'b1;
        else if (!use_ok) res_c.table_full = 1'b1;
        else if (a_cur < cfg.max_conn) res_c.granted = 1'b1;
      end
      psl_pkg::ACT_QUERY: begin
        res_c.in_cooldown = !q_off && hit_r && ce_cur > now_r;
      end
      psl_pkg::ACT_FAIL: begin
        if (!f_off) begin
          if (!use_ok) res_c.table_full = 1'b1;
          else if (f_new >= cfg.threshold) res_c.cooldown_started = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOOK;
      valid_r  <= '0;
      now_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (state_r == ST_EXEC) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        ST_LOOK: begin
          if (q_valid && q_ready) begin
            item_r  <= q_data;
            hit_r   <= hit_c;
            hidx_r  <= hidx_c;
            free_r  <= free_c;
            fidx_r  <= fidx_c;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_r    <= res_c;
          state_r  <= ST_LOOK;
          case (item_r.action)
            psl_pkg::ACT_ACQUIRE: begin
              if (!acq_off && use_ok) begin
                if (need_alloc) begin
                  valid_r[ix] <= 1'b1; key_r[ix] <= item_r.source_addr;
                  fcnt_r[ix] <= '0; wopen_r[ix] <= 1'b0;
                  wst_r[ix] <= '0; cend_r[ix] <= '0;
                end
                if (a_cur < cfg.max_conn) act_r[ix] <= a_cur + 16'd1;
                else act_r[ix] <= a_cur;
              end
            end
            psl_pkg::ACT_RELEASE: begin
              if (!acq_off && hit_r) begin
                act_r[ix] <= (a_cur != 16'd0) ? a_cur - 16'd1 : 16'd0;
                if (a_cur <= 16'd1 && f_cur == 8'd0 && ce_cur <= now_r)
                  valid_r[ix] <= 1'b0;
              end
            end
            psl_pkg::ACT_FAIL: begin
              if (!f_off && use_ok) begin
                if (need_alloc) begin
                  valid_r[ix] <= 1'b1; key_r[ix] <= item_r.source_addr;
                  act_r[ix] <= '0;
                end
                wopen_r[ix] <= 1'b1;
                if (f_new >= cfg.threshold) begin
                  cend_r[ix] <= cend_sum[32] ? 32'hFFFF_FFFF : cend_sum[31:0];
                  fcnt_r[ix] <= 8'd0;
                  wst_r[ix]  <= now_r;
                end else begin
                  if (need_alloc) cend_r[ix] <= '0;
                  fcnt_r[ix] <= f_new;
                  wst_r[ix]  <= restart ? now_r : ws_cur;
                end
              end
            end
            psl_pkg::ACT_TICK: begin
              if (now_r != 32'hFFFF_FFFF) now_r <= now_r + 32'd1;
            end
            default: ;
          endcase
        end
        default: state_r <= ST_LOOK;
      endcase
    end
  end

  `PSL_ASSERT_NEXT(a_exec_after_take, clk, rst_n, q_valid && q_ready, state_r == ST_EXEC,
    "lookup not followed by execution")
  `PSL_ASSERT_NEXT(a_result_after_exec, clk, rst_n, state_r == ST_EXEC, ovalid_r,
    "execution produced no result")
  `PSL_ASSERT_IMP(a_no_take_in_exec, clk, rst_n, state_r == ST_EXEC, !q_ready,
    "queue popped during execution")
endmodule
`default_nettype wire

@@ design/per_source_connection_and_auth_limiter.sv @@
`default_nettype none
// Per-source connection limiter with authentication-failure cooldown.
// Input channel in_valid/in_ready/in_data carries one word: an action
// (acquire, release, query, failure, tick) and a source address. Each word
// gives exactly one result word on out_valid/out_ready/out_data with the
// granted, in_cooldown, cooldown_started and table_full flags.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce; cfg_ready is always high. A two-word queue decouples the
// input from the table engine. The engine handles one word at a time: a lookup
// state over the whole table, then an update state; no new word leaves the
// queue until the update is done. The queue, the lookup registers and the output register lie before out_valid.
// A stalled receiver holds the result in the output register; the engine
// then waits and the queue fills, after which in_ready falls.
// Synchronous reset clears the table valid bits, the seconds clock, the cfg
// registers, the queue and the output register; no clearing pass is needed.
module per_source_connection_and_auth_limiter #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire psl_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output psl_pkg::out_word_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  psl_pkg::cfg_t     cfg_r;
  logic              q_valid, q_ready;
  psl_pkg::in_word_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_valid) begin
      case (cfg_index)
        psl_pkg::CFG_ENABLE:    cfg_r.enable    <= cfg_data[0];
        psl_pkg::CFG_MAX_CONN:  cfg_r.max_conn  <= cfg_data;
        psl_pkg::CFG_THRESHOLD: cfg_r.threshold <= cfg_data[7:0];
        psl_pkg::CFG_WINDOW:    cfg_r.window    <= cfg_data;
        psl_pkg::CFG_COOLDOWN:  cfg_r.cooldown  <= cfg_data;
        default: ;
      endcase
    end
  end

  psl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  psl_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
